// File: hdl/rcr_pkg.sv
// ---------------------------------------------------------------------------
// rcr_pkg
// Types and codes shared by the request cache replacement block.
// ---------------------------------------------------------------------------
package rcr_pkg;

    // Field widths of one transaction
    localparam int ACTION_W  = 2;
    localparam int KIND_W    = 3;
    localparam int INDEX_W   = 31;
    localparam int KEYWORD_W = 32;
    localparam int PAYLOAD_W = 16;
    localparam int TIME_W    = 32;
    localparam int USES_W    = 14;
    localparam int COUNT_W   = 5;
    localparam int POLICY_W  = 2;
    localparam int CAP_W     = 5;

    // Stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 40;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_LOOKUP     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_INVALIDATE = 2'd2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_GET    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LINES  = 3'd3;

    // Replacement policies
    localparam logic [POLICY_W-1:0] POL_NONE = 2'd0;
    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd1;
    localparam logic [POLICY_W-1:0] POL_TIME = 2'd2;
    localparam logic [POLICY_W-1:0] POL_FREQ = 2'd3;

    // Register indexes on the APB port
    localparam logic REG_POLICY   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [USES_W-1:0] USES_MAX  = 14'd16383;

    // One cache entry as held in the slot memory
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [INDEX_W-1:0]   index;
        logic [KEYWORD_W-1:0] keyword;
        logic [PAYLOAD_W-1:0] payload;
        logic [USES_W-1:0]    uses;
        logic [TIME_W-1:0]    stamp;
    } entry_t;

    // Kinds that may be cached
    function automatic logic kept_kind(input logic [KIND_W-1:0] k);
        return (k == KIND_GET) || (k == KIND_DELETE) || (k == KIND_LINES);
    endfunction

endpackage

// File: hdl/request_cache_replacement.sv
// ---------------------------------------------------------------------------
// request_cache_replacement
// Ordered request result cache with none, FIFO, time stamp or frequency
// replacement.
// ---------------------------------------------------------------------------
// The block takes one transaction at a time and answers each with exactly one
// result transaction. All entries live in a single slot memory with one read
// and one write port; a small sequencer walks it one entry per cycle through
// one shared compare unit. A lookup walks the valid entries until a hit; an
// insert with room left appends at the tail without a walk; an insert that
// evicts under the frequency policy searches for the victim and writes into
// its slot; one that evicts under FIFO or time stamp closes up the gap one
// entry per cycle (after a search for the oldest entry under time stamp) and
// then appends; an invalidate closes up over all entries. A new transaction
// is accepted while a previous result still waits on the master side. The
// slot memory needs no clearing after reset.
// ---------------------------------------------------------------------------
module request_cache_replacement
    import rcr_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // APB configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // action[1:0], key_index[32:2], keyword_tag[64:33], payload_in[80:65],
    // time_now[112:81], zero pad above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // request_kind[2:0]
    input  logic [KIND_W-1:0]      s_tuser,
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // hit[0], payload_out[16:1], evicted[17], evicted_payload[33:18],
    // stored_count[38:34], zero pad above
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_SHIFT    = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    // Scan modes
    localparam logic [1:0] MODE_LOOK   = 2'd0;
    localparam logic [1:0] MODE_MINUSE = 2'd1;
    localparam logic [1:0] MODE_OLDEST = 2'd2;

    // Registers
    logic [2:0]             state_reg, state_next;
    logic [1:0]             mode_reg, mode_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          pidx_reg, pidx_next;
    logic [CW-1:0]          wp_reg, wp_next;
    logic [AW-1:0]          victim_reg, victim_next;
    logic                   drop_by_index_reg, drop_by_index_next;
    logic                   ins_after_reg, ins_after_next;
    logic [AW-1:0]          best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]      best_key_reg, best_key_next;
    logic [PAYLOAD_W-1:0]   best_pay_reg, best_pay_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [POLICY_W-1:0]    policy_reg;
    logic [CAP_W-1:0]       cap_reg;

    logic [ACTION_W-1:0]    act_reg;
    logic [KIND_W-1:0]      kind_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic [KEYWORD_W-1:0]   kw_reg;
    logic [PAYLOAD_W-1:0]   pay_reg;
    logic [TIME_W-1:0]      now_reg;

    logic                   res_hit_reg, res_hit_next;
    logic [PAYLOAD_W-1:0]   res_pay_reg, res_pay_next;
    logic                   res_ev_reg, res_ev_next;
    logic [PAYLOAD_W-1:0]   res_evpay_reg, res_evpay_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Slot memory
    entry_t                 slot_mem [ENTRIES];
    entry_t                 rd_data_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    entry_t                 mem_wd;
    logic [AW-1:0]          mem_ra;

    // Combinational helpers
    logic                   s_fire;
    logic                   cfg_wr;
    logic [LW-1:0]          cap_ext, fill_ext, lim;
    logic                   full;
    logic                   pol_on;
    entry_t                 fresh_entry;
    entry_t                 upd_entry;
    logic                   look_match;
    logic [TIME_W-1:0]      cmp_key;
    logic                   cmp_take;
    logic                   scan_end;
    logic                   shift_drop;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // APB access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_POLICY:   prdata = {{(32 - POLICY_W){1'b0}}, policy_reg};
            REG_CAPACITY: prdata = {{(32 - CAP_W){1'b0}}, cap_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_NONE;
            cap_reg    <= CAP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_POLICY) begin
                policy_reg <= pwdata[POLICY_W-1:0];
            end else begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
        end
    end

    // Effective capacity, clamped to 1..ENTRIES
    assign cap_ext  = LW'(cap_reg);
    assign fill_ext = LW'(fill_reg);
    always_comb begin
        if (cap_reg == '0) begin
            lim = LW'(1);
        end else if (cap_ext > LW'(ENTRIES)) begin
            lim = LW'(ENTRIES);
        end else begin
            lim = cap_ext;
        end
    end
    assign full   = (fill_ext >= lim);
    assign pol_on = (policy_reg != POL_NONE);

    // Entry built from the current request
    always_comb begin
        fresh_entry.kind    = kind_reg;
        fresh_entry.index   = idx_reg;
        fresh_entry.keyword = kw_reg;
        fresh_entry.payload = pay_reg;
        fresh_entry.uses    = USES_W'(1);
        fresh_entry.stamp   = now_reg;
    end

    // Entry read back with its hit refresh applied
    always_comb begin
        upd_entry = rd_data_reg;
        if (policy_reg == POL_TIME) begin
            upd_entry.stamp = now_reg;
        end else if (policy_reg == POL_FREQ && rd_data_reg.uses != USES_MAX) begin
            upd_entry.uses = rd_data_reg.uses + USES_W'(1);
        end
    end

    assign look_match = (rd_data_reg.kind == kind_reg) && (rd_data_reg.index == idx_reg)
                        && ((kind_reg != KIND_LINES) || (rd_data_reg.keyword == kw_reg));

    // Shared compare unit: least uses (first wins) or oldest stamp (last wins)
    assign cmp_key  = (mode_reg == MODE_MINUSE) ? TIME_W'(rd_data_reg.uses)
                                                : rd_data_reg.stamp;
    assign cmp_take = (pidx_reg == '0) || (cmp_key < best_key_reg)
                      || ((mode_reg == MODE_OLDEST) && (cmp_key == best_key_reg));

    assign scan_end   = !pend_reg && (ptr_reg >= fill_reg);
    assign shift_drop = drop_by_index_reg ? (rd_data_reg.index == idx_reg)
                                          : (pidx_reg == victim_reg);
    assign mem_ra     = ptr_reg[AW-1:0];

    // Sequencer
    always_comb begin
        state_next         = state_reg;
        mode_next          = mode_reg;
        ptr_next           = ptr_reg;
        pend_next          = 1'b0;
        pidx_next          = pidx_reg;
        wp_next            = wp_reg;
        victim_next        = victim_reg;
        drop_by_index_next = drop_by_index_reg;
        ins_after_next     = ins_after_reg;
        best_idx_next      = best_idx_reg;
        best_key_next      = best_key_reg;
        best_pay_next      = best_pay_reg;
        fill_next          = fill_reg;
        res_hit_next       = res_hit_reg;
        res_pay_next       = res_pay_reg;
        res_ev_next        = res_ev_reg;
        res_evpay_next     = res_evpay_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        m_tdata_next       = m_tdata_reg;
        mem_we             = 1'b0;
        mem_wa             = '0;
        mem_wd             = fresh_entry;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    res_hit_next   = 1'b0;
                    res_pay_next   = '0;
                    res_ev_next    = 1'b0;
                    res_evpay_next = '0;
                    state_next     = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                ptr_next           = '0;
                wp_next            = '0;
                drop_by_index_next = 1'b0;
                ins_after_next     = 1'b0;
                victim_next        = '0;
                state_next         = ST_DONE;
                if (pol_on && act_reg == ACT_LOOKUP && kept_kind(kind_reg)) begin
                    mode_next  = MODE_LOOK;
                    state_next = ST_SCAN;
                end else if (pol_on && act_reg == ACT_INSERT && kept_kind(kind_reg)) begin
                    if (!full) begin
                        // Room left: append at the tail
                        mem_we    = 1'b1;
                        mem_wa    = fill_reg[AW-1:0];
                        fill_next = fill_reg + CW'(1);
                    end else if (policy_reg == POL_FREQ) begin
                        mode_next  = MODE_MINUSE;
                        state_next = ST_SCAN;
                    end else if (policy_reg == POL_TIME) begin
                        mode_next  = MODE_OLDEST;
                        state_next = ST_SCAN;
                    end else begin
                        // FIFO: evict the head, close up, then append
                        res_ev_next    = 1'b1;
                        ins_after_next = 1'b1;
                        state_next     = ST_SHIFT;
                    end
                end else if (pol_on && act_reg == ACT_INVALIDATE
                             && kind_reg == KIND_DELETE) begin
                    drop_by_index_next = 1'b1;
                    state_next         = ST_SHIFT;
                end
            end

            ST_SCAN: begin
                // Issue the next read while the previous entry is examined
                if (ptr_reg < fill_reg) begin
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[AW-1:0];
                end
                if (pend_reg) begin
                    if (mode_reg == MODE_LOOK) begin
                        if (look_match) begin
                            res_hit_next = 1'b1;
                            res_pay_next = rd_data_reg.payload;
                            mem_we       = 1'b1;
                            mem_wa       = pidx_reg;
                            mem_wd       = upd_entry;
                            state_next   = ST_DONE;
                        end
                    end else if (cmp_take) begin
                        best_idx_next = pidx_reg;
                        best_key_next = cmp_key;
                        best_pay_next = rd_data_reg.payload;
                    end
                end
                if (scan_end) begin
                    unique case (mode_reg)
                        MODE_MINUSE: begin
                            // Frequency: new entry takes the victim's slot
                            res_ev_next    = 1'b1;
                            res_evpay_next = best_pay_reg;
                            mem_we         = 1'b1;
                            mem_wa         = best_idx_reg;
                            state_next     = ST_DONE;
                        end
                        MODE_OLDEST: begin
                            res_ev_next    = 1'b1;
                            victim_next    = best_idx_reg;
                            ptr_next       = CW'(best_idx_reg);
                            wp_next        = CW'(best_idx_reg);
                            ins_after_next = 1'b1;
                            pend_next      = 1'b0;
                            state_next     = ST_SHIFT;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SHIFT: begin
                // Compaction pass: copy kept entries down to the write pointer
                if (ptr_reg < fill_reg) begin
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[AW-1:0];
                end
                if (pend_reg) begin
                    if (shift_drop) begin
                        if (!drop_by_index_reg) begin
                            res_evpay_next = rd_data_reg.payload;
                        end
                    end else begin
                        mem_we  = 1'b1;
                        mem_wa  = wp_reg[AW-1:0];
                        mem_wd  = rd_data_reg;
                        wp_next = wp_reg + CW'(1);
                    end
                end
                if (scan_end) begin
                    fill_next  = wp_reg;
                    state_next = ST_DONE;
                    if (ins_after_reg) begin
                        mem_we    = 1'b1;
                        mem_wa    = wp_reg[AW-1:0];
                        mem_wd    = fresh_entry;
                        fill_next = wp_reg + CW'(1);
                    end
                end
            end

            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, fill_ext[COUNT_W-1:0], res_evpay_reg, res_ev_reg,
                                     res_pay_reg, res_hit_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        mode_reg          <= mode_next;
        ptr_reg           <= ptr_next;
        pidx_reg          <= pidx_next;
        wp_reg            <= wp_next;
        victim_reg        <= victim_next;
        drop_by_index_reg <= drop_by_index_next;
        ins_after_reg     <= ins_after_next;
        best_idx_reg      <= best_idx_next;
        best_key_reg      <= best_key_next;
        best_pay_reg      <= best_pay_next;
        res_hit_reg       <= res_hit_next;
        res_pay_reg       <= res_pay_next;
        res_ev_reg        <= res_ev_next;
        res_evpay_reg     <= res_evpay_next;
        m_tdata_reg       <= m_tdata_next;
        if (s_fire) begin
            act_reg  <= s_tdata[1:0];
            kind_reg <= s_tuser;
            idx_reg  <= s_tdata[32:2];
            kw_reg   <= s_tdata[64:33];
            pay_reg  <= s_tdata[80:65];
            now_reg  <= s_tdata[112:81];
        end
    end

    // Slot memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= slot_mem[mem_ra];
    end

endmodule
